/* src/mrsp_pkg.sv */
// Shared types and constants for the MIDI running-status parser.
// No dependencies; used by mrsp_decode and midi_running_status_parser_core.
`timescale 1ns / 1ps
`default_nettype none

package mrsp_pkg;

  // Byte codes
  localparam logic [7:0] BYTE_IDLE = 8'hFF;
  localparam logic [7:0] CTRL_ELEMENT = 8'h53;

  // Status kinds (upper nibble of the status byte)
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON = 4'h9;
  localparam logic [3:0] KIND_POLY_PRESS = 4'hA;
  localparam logic [3:0] KIND_CTRL_CHANGE = 4'hB;
  localparam logic [3:0] KIND_PROG_CHANGE = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
  localparam logic [3:0] KIND_PITCH_BEND = 4'hE;

  // Bytes collected including status
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_STATUS = 2'd1,
    CNT_DATA1 = 2'd2,
    CNT_FULL = 2'd3
  } cnt_t;

  localparam logic [1:0] ELM_MAX = 2'd3;

  typedef struct packed {
    logic [7:0] pend_status;
    logic [6:0] first_data;
    cnt_t       cnt;
    logic [7:0] run_status;
  } parse_st_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic       element_event;
    logic       beat_on;
    logic [3:0] beat_cell;
    logic [1:0] element_number;
  } msg_t;

endpackage

`default_nettype wire

/* src/mrsp_decode.sv */
// Per-byte decode: next parser state and the completed message, if any.
// Depends on mrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrsp_decode (
  input  wire logic [7:0]         rx_byte,
  input  wire mrsp_pkg::parse_st_t st,
  output mrsp_pkg::parse_st_t     st_nxt,
  output logic                    done,
  output mrsp_pkg::msg_t          msg
);

  logic [7:0]    ps;
  mrsp_pkg::cnt_t c;
  logic [3:0]    kind;
  logic [1:0]    elm;
  logic          is_elm;

  always_comb begin
    // running status picks up when nothing is pending
    ps = (st.cnt == mrsp_pkg::CNT_NONE) ? st.run_status : st.pend_status;
    c = (st.cnt == mrsp_pkg::CNT_NONE) ? mrsp_pkg::CNT_STATUS : st.cnt;
    kind = ps[7:4];
    elm = (rx_byte[5:4] == mrsp_pkg::ELM_MAX) ? mrsp_pkg::ELM_MAX : rx_byte[5:4] + 2'd1;
    is_elm = (kind == mrsp_pkg::KIND_CTRL_CHANGE) &&
             ({1'b0, st.first_data} == mrsp_pkg::CTRL_ELEMENT);

    st_nxt = st;
    done = 1'b0;
    msg = '0;
    msg.status = ps;
    msg.data1 = (c == mrsp_pkg::CNT_STATUS) ? rx_byte[6:0] : st.first_data;

    if (rx_byte == mrsp_pkg::BYTE_IDLE) begin
      st_nxt = st;
    end else if (rx_byte[7]) begin
      st_nxt.pend_status = rx_byte;
      st_nxt.cnt = mrsp_pkg::CNT_STATUS;
    end else begin
      st_nxt.pend_status = ps;
      unique case (c)
        mrsp_pkg::CNT_STATUS: begin
          st_nxt.first_data = rx_byte[6:0];
          st_nxt.cnt = mrsp_pkg::CNT_DATA1;
          done = (kind == mrsp_pkg::KIND_PROG_CHANGE) || (kind == mrsp_pkg::KIND_CHAN_PRESS);
        end
        mrsp_pkg::CNT_DATA1: begin
          st_nxt.cnt = mrsp_pkg::CNT_FULL;
          done = (kind == mrsp_pkg::KIND_NOTE_OFF) || (kind == mrsp_pkg::KIND_NOTE_ON) ||
                 (kind == mrsp_pkg::KIND_POLY_PRESS) ||
                 (kind == mrsp_pkg::KIND_CTRL_CHANGE) ||
                 (kind == mrsp_pkg::KIND_PITCH_BEND);
          msg.data2 = rx_byte[6:0];
          if (is_elm) begin
            msg.data2 = {rx_byte[6], elm, rx_byte[3:0]};
            msg.element_event = 1'b1;
            msg.beat_on = rx_byte[6];
            msg.beat_cell = rx_byte[3:0];
            msg.element_number = elm;
          end
        end
        default: begin
          // stuck: system or unknown status, drop data
          st_nxt.cnt = mrsp_pkg::CNT_FULL;
        end
      endcase
      if (done) begin
        st_nxt.run_status = ps;
        st_nxt.cnt = mrsp_pkg::CNT_NONE;
      end
    end
  end

endmodule

`default_nettype wire

/* src/midi_running_status_parser_core.sv */
// Top level of the MIDI running-status parser: input register, decode, result register.
// Depends on mrsp_pkg and mrsp_decode.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one received MIDI byte per word on the in_ channel and emits one word per
// completed channel message on the out_ channel. A byte is taken every clock while the
// result side keeps up; a result shows on out_valid once its last byte has passed from the
// input register through decode into the result register, and a stalled result side holds
// that byte in the input register. 0xFF bytes are ignored,
// status bytes restart assembly, and data bytes with nothing pending reuse the last
// completed status. Control change 0x53 is reported as an element command with the
// beat fields filled in; otherwise those fields read 0.
module midi_running_status_parser_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_msg_status,
  output logic [6:0]      out_msg_data1,
  output logic [6:0]      out_msg_data2,
  output logic            out_element_event,
  output logic            out_beat_on,
  output logic [3:0]      out_beat_cell,
  output logic [1:0]      out_element_number
);

  // input stage
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // parser state, updated when a byte leaves the input stage
  mrsp_pkg::parse_st_t st_r;
  mrsp_pkg::parse_st_t st_nxt;

  // result register
  logic           out_vld_r;
  mrsp_pkg::msg_t msg_r;
  mrsp_pkg::msg_t msg_nxt;
  logic           done;
  logic           adv;

  mrsp_decode u_decode (
    .rx_byte (in_byte_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .done    (done),
    .msg     (msg_nxt)
  );

  // input stage moves on when the result slot is free or draining this cycle
  assign adv = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && done) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && done) begin
      msg_r <= msg_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_msg_status = msg_r.status;
  assign out_msg_data1 = msg_r.data1;
  assign out_msg_data2 = msg_r.data2;
  assign out_element_event = msg_r.element_event;
  assign out_beat_on = msg_r.beat_on;
  assign out_beat_cell = msg_r.beat_cell;
  assign out_element_number = msg_r.element_number;

  // an element command is always a control change on controller 0x53
  a_elm_is_cc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && msg_r.element_event) |->
      (msg_r.status[7:4] == mrsp_pkg::KIND_CTRL_CHANGE) &&
      ({1'b0, msg_r.data1} == mrsp_pkg::CTRL_ELEMENT) && (msg_r.element_number != 2'd0))
    else $error("element event on a non-element message");

  // beat fields stay clear outside element commands
  a_beat_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !msg_r.element_event) |->
      (!msg_r.beat_on && (msg_r.beat_cell == 4'd0) && (msg_r.element_number == 2'd0)))
    else $error("beat fields set without element event");

  // one-data-byte messages carry a zero second byte
  a_one_byte_d2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && ((msg_r.status[7:4] == mrsp_pkg::KIND_PROG_CHANGE) ||
                   (msg_r.status[7:4] == mrsp_pkg::KIND_CHAN_PRESS))) |->
      (msg_r.data2 == 7'd0))
    else $error("nonzero data2 on a one-data-byte message");

  // a stalled result blocks the pipe only while the input stage is full
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("input stage empty but not ready");

  // a completed message always has a status byte
  a_status_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> msg_r.status[7])
    else $error("result without a status byte");

endmodule

`default_nettype wire
